// ===== rtl/dqp_pkg.sv =====
// ----------------------------------------------------------------------------
// dqp_pkg: shared types and character codes for the dotted-quad parser
// Beat payloads, parser state, and the per-character update function.
// ----------------------------------------------------------------------------
package dqp_pkg;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [11:0] OCTET_MAX = 12'd255;
	localparam logic [1:0]  LAST_IDX  = 2'd3;

	typedef enum logic [3:0] {
		PH_SKIP    = 4'b0001,
		PH_START   = 4'b0010,
		PH_DIGITS  = 4'b0100,
		PH_DECIDED = 4'b1000
	} dqp_phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_last;
	} dqp_in_t;

	typedef struct packed {
		logic [7:0] octet_a;
		logic [7:0] octet_b;
		logic [7:0] octet_c;
		logic [7:0] octet_d;
		logic       failed;
	} dqp_out_t;

	typedef struct packed {
		dqp_phase_t      phase;
		logic [1:0]      idx;
		logic [7:0]      acc;
		logic [2:0][7:0] done;
		logic            failed;
	} dqp_state_t;

	localparam dqp_state_t STATE_RESET = '{
		phase:  PH_SKIP,
		idx:    2'd0,
		acc:    8'd0,
		done:   24'd0,
		failed: 1'b0
	};

	// Advance the parser by one character.
	function automatic dqp_state_t feed(dqp_state_t st, logic [7:0] c);
		dqp_state_t  nx;
		logic        is_dig;
		logic        is_term;
		logic        start;
		logic [3:0]  dig;
		logic [7:0]  dig8;
		logic [11:0] v;
		nx      = st;
		start   = 1'b0;
		is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
		is_term = (c == CH_NUL) || (c == CH_SPACE) || (c == CH_TAB) ||
		          (c == CH_CR) || (c == CH_LF);
		dig8    = c - CH_ZERO;
		dig     = dig8[3:0];
		v       = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0} + {8'd0, dig};
		unique case (st.phase)
			PH_SKIP: begin
				if (!((c == CH_SPACE) || (c == CH_TAB)))
					start = 1'b1;
			end
			PH_START: start = 1'b1;
			PH_DIGITS: begin
				if (is_dig) begin
					if (v > OCTET_MAX) begin
						nx.failed = 1'b1;
						nx.phase  = PH_DECIDED;
					end else begin
						nx.acc = v[7:0];
					end
				end else if (st.idx != LAST_IDX) begin
					if (c != CH_DOT) begin
						nx.failed = 1'b1;
						nx.phase  = PH_DECIDED;
					end else begin
						nx.done[st.idx] = st.acc;
						nx.idx          = st.idx + 2'd1;
						nx.acc          = 8'd0;
						nx.phase        = PH_START;
					end
				end else begin
					nx.failed = !is_term;
					nx.phase  = PH_DECIDED;
				end
			end
			PH_DECIDED: ;
			default: ;
		endcase
		if (start) begin
			if (!is_dig) begin
				nx.failed = 1'b1;
				nx.phase  = PH_DECIDED;
			end else begin
				nx.acc   = {4'd0, dig};
				nx.phase = PH_DIGITS;
			end
		end
		return nx;
	endfunction

endpackage

// ===== rtl/dqp_step.sv =====
// ----------------------------------------------------------------------------
// dqp_step: per-beat parser update
// Feeds one character, closes the string with an implied NUL on the last
// beat, and forms the result and the next state.
// ----------------------------------------------------------------------------
module dqp_step (
	input  dqp_pkg::dqp_state_t cur,
	input  dqp_pkg::dqp_in_t    beat,
	output dqp_pkg::dqp_state_t nxt,
	output dqp_pkg::dqp_out_t   res
);

	dqp_pkg::dqp_state_t mid;
	dqp_pkg::dqp_state_t fin;

	assign mid = dqp_pkg::feed(cur, beat.ch);
	assign fin = dqp_pkg::feed(mid, dqp_pkg::CH_NUL);

	// A string that ends before the verdict is decided gets the implied NUL.
	always_comb begin
		if (fin.failed) begin
			res = '{octet_a: 8'd0, octet_b: 8'd0, octet_c: 8'd0, octet_d: 8'd0,
			        failed: 1'b1};
		end else begin
			res = '{octet_a: fin.done[0], octet_b: fin.done[1], octet_c: fin.done[2],
			        octet_d: fin.acc, failed: 1'b0};
		end
	end

	// Drop back to the idle state after the last beat.
	assign nxt = beat.is_last ? dqp_pkg::STATE_RESET : mid;

endmodule

// ===== rtl/dotted_quad_ipv4_parser.sv =====
// ----------------------------------------------------------------------------
// dotted_quad_ipv4_parser: streaming dotted-decimal IPv4 address parser
// Takes one character per input beat, returns one address verdict per string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_data) carries one character per
//   beat plus is_last, which marks the final character of a string. Leading
//   spaces and tabs are skipped; four dot-separated decimal octets follow,
//   ended by NUL, space, tab, CR, LF or the end of the string.
//   Output channel (out_valid / out_ready / out_data) carries one beat per
//   string, produced by the is_last character: four octets and failed. On a
//   malformed or out-of-range string, failed is set and all octets are zero.
//   Throughput: one character per cycle, except while a last character waits
//   on a blocked result (see Stall). The parser state is updated as a beat
//   leaves the input register; the result beat of its last character is
//   written to the result register, which drives out_valid.
//   Stall: while a result waits on out_ready, non-final characters still flow;
//   the next last character holds in the input register, and in_ready drops,
//   until the waiting result is taken.
//   Reset: arst_n clears both registers' valid flags and returns the parser to
//   skipping leading whitespace.
// ----------------------------------------------------------------------------
module dotted_quad_ipv4_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dqp_pkg::dqp_in_t    in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output dqp_pkg::dqp_out_t   out_data
);

	logic                s1_valid_s1;
	dqp_pkg::dqp_in_t    s1_data_s1;
	logic                s1_adv;
	dqp_pkg::dqp_state_t state_q;
	dqp_pkg::dqp_state_t state_nxt;
	dqp_pkg::dqp_out_t   res;
	logic                out_valid_q;
	dqp_pkg::dqp_out_t   out_data_q;

	// Advance the input register unless its beat would produce a result that
	// has nowhere to go.
	assign s1_adv   = s1_valid_s1 && (!s1_data_s1.is_last || !out_valid_q || out_ready);
	assign in_ready = !s1_valid_s1 || s1_adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			s1_data_s1 <= in_data;
	end

	dqp_step u_step (
		.cur  (state_q),
		.beat (s1_data_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqp_pkg::STATE_RESET;
		end else if (s1_adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && s1_data_s1.is_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_data_s1.is_last)
			out_data_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Assertions
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && s1_data_s1.is_last) |=> (state_q == dqp_pkg::STATE_RESET))
		else $error("parser state not cleared after last beat");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (s1_valid_s1 && s1_data_s1.is_last && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.failed) |->
		(out_data_q.octet_a == 8'd0 && out_data_q.octet_b == 8'd0 &&
		 out_data_q.octet_c == 8'd0 && out_data_q.octet_d == 8'd0))
		else $error("failed result carries nonzero octets");

endmodule
